/* sv/imu_fd_pkg.sv */
// ----------------------------------------------------------------------------
// imu_fd_pkg
// Shared types, frame layout constants and marker tables of the IMU deframer.
// ----------------------------------------------------------------------------
package imu_fd_pkg;

  // Default frame geometry
  localparam int FRAME_LEN_DEF = 68;
  localparam int BUF_SIZE_DEF  = 128;
  localparam int HEAD2_POS_DEF = 6;
  localparam int HEAD3_POS_DEF = 21;
  localparam int HEAD4_POS_DEF = 51;

  // Fixed capture offsets of the two word groups
  localparam logic [7:0] ACC_BASE = 8'd9;
  localparam logic [7:0] ANG_BASE = 8'd54;
  localparam logic [7:0] GRP_SPAN = 8'd12;
  localparam int         NWORDS   = 6;
  localparam int         GRP_WORDS = 3;

  // Header block lengths and tail marker
  localparam logic [7:0] HEAD1_LEN = 8'd6;
  localparam logic [7:0] HEADN_LEN = 8'd3;
  localparam logic [7:0] TAIL_BYTE = 8'h6D;

  // Item opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_IDLE = 1'b1;

  // Frame status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEN  = 2'd1;
  localparam logic [1:0] ST_BAD_MARK = 2'd2;
  localparam logic [1:0] ST_BAD_SUM  = 2'd3;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [31:0] accel_x_bits;
    logic [31:0] accel_y_bits;
    logic [31:0] accel_z_bits;
    logic [31:0] roll_bits;
    logic [31:0] pitch_bits;
    logic [31:0] yaw_bits;
  } out_item_t;

  // Leading header: 41 78 FF 06 81 47
  function automatic logic [7:0] head1_pat(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'h41;
      3'd1:    v = 8'h78;
      3'd2:    v = 8'hFF;
      3'd3:    v = 8'h06;
      3'd4:    v = 8'h81;
      3'd5:    v = 8'h47;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Second marker: 00 8C 0C
  function automatic logic [7:0] head2_pat(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = 8'h00;
      2'd1:    v = 8'h8C;
      2'd2:    v = 8'h0C;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Third marker: 02 8C 0C
  function automatic logic [7:0] head3_pat(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = 8'h02;
      2'd1:    v = 8'h8C;
      2'd2:    v = 8'h0C;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Fourth marker: 01 B0 10
  function automatic logic [7:0] head4_pat(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = 8'h01;
      2'd1:    v = 8'hB0;
      2'd2:    v = 8'h10;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

/* sv/imu_frame_deframer.sv */
// ----------------------------------------------------------------------------
// imu_frame_deframer
// Deframes IMU byte streams, checks markers, length and XOR checksum, and
// reports a status with the last good acceleration and angle words.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one item per handshake, either a received byte or an idle-gap
//            event that closes the current frame.
//   out_*  : one item per idle event: frame status plus the last good six
//            words (updated by this event when the frame checks out).
//   Bytes produce no output item.
// Path: an item is held in the input register and is processed as it
//   leaves; an idle event's status item is registered in the result
//   register as the event leaves and then shows on out_*.
// Throughput: one item per cycle while no idle event waits on the single
//   output register; a byte still moves through while a status item waits,
//   and an idle event waits only for that register to free up.
// Reset: synchronous, clears all frame state, the staged and good words
//   and both pipeline valids.
// Stall: while out_ready is low the status item holds; bytes keep flowing
//   and the next idle event holds in the input register, dropping in_ready.
// ----------------------------------------------------------------------------
module imu_frame_deframer #(
  parameter int FRAME_LEN = imu_fd_pkg::FRAME_LEN_DEF,
  parameter int BUF_SIZE  = imu_fd_pkg::BUF_SIZE_DEF,
  parameter int HEAD2_POS = imu_fd_pkg::HEAD2_POS_DEF,
  parameter int HEAD3_POS = imu_fd_pkg::HEAD3_POS_DEF,
  parameter int HEAD4_POS = imu_fd_pkg::HEAD4_POS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  imu_fd_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output imu_fd_pkg::out_item_t out_data
);
  import imu_fd_pkg::*;

  localparam logic [7:0] FL      = 8'(FRAME_LEN);
  localparam logic [7:0] FL_SUM  = 8'(FRAME_LEN - 2);
  localparam logic [7:0] FL_TAIL = 8'(FRAME_LEN - 1);
  localparam logic [7:0] BUF_MAX = 8'(BUF_SIZE);
  localparam logic [7:0] H2      = 8'(HEAD2_POS);
  localparam logic [7:0] H3      = 8'(HEAD3_POS);
  localparam logic [7:0] H4      = 8'(HEAD4_POS);

  // Input register
  logic     s1_valid_r;
  in_item_t s1_item_r;

  // Frame state
  logic [7:0]  count_r,     count_nxt;
  logic [7:0]  xor_r,       xor_nxt;
  logic        mark_bad_r,  mark_bad_nxt;
  logic        sum_bad_r,   sum_bad_nxt;
  logic [31:0] staged_r [NWORDS];
  logic [31:0] staged_nxt [NWORDS];
  logic [31:0] good_r [NWORDS];
  logic [31:0] good_nxt [NWORDS];

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  status_r,    status_nxt;

  logic        s1_adv;
  logic        is_byte, is_idle, take_byte;
  logic [7:0]  p, b;
  logic [7:0]  off2, off3, off4, off_acc, off_ang;
  logic        miss1, miss2, miss3, miss4, miss_tail;
  logic        cap_en;
  logic [2:0]  cap_k;
  logic [1:0]  cap_lane;

  // Advance the input item unless it is an idle event blocked by a held result
  assign is_byte  = s1_item_r.opcode == OP_BYTE;
  assign is_idle  = s1_item_r.opcode == OP_IDLE;
  assign s1_adv   = s1_valid_r && (is_byte || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  assign p = count_r;
  assign b = s1_item_r.rx_byte;

  // Marker compares, each marker on its own
  always_comb begin
    off2 = p - H2;
    off3 = p - H3;
    off4 = p - H4;
    miss1     = (p < HEAD1_LEN) && (b != head1_pat(p[2:0]));
    miss2     = (p >= H2) && (off2 < HEADN_LEN) && (b != head2_pat(off2[1:0]));
    miss3     = (p >= H3) && (off3 < HEADN_LEN) && (b != head3_pat(off3[1:0]));
    miss4     = (p >= H4) && (off4 < HEADN_LEN) && (b != head4_pat(off4[1:0]));
    miss_tail = (p == FL_TAIL) && (b != TAIL_BYTE);
  end

  // Locate the word and byte lane to capture
  always_comb begin
    off_acc  = p - ACC_BASE;
    off_ang  = p - ANG_BASE;
    cap_en   = 1'b0;
    cap_k    = '0;
    cap_lane = '0;
    if ((p >= ACC_BASE) && (off_acc < GRP_SPAN)) begin
      cap_en   = 1'b1;
      cap_k    = {1'b0, off_acc[3:2]};
      cap_lane = off_acc[1:0];
    end else if ((p >= ANG_BASE) && (off_ang < GRP_SPAN)) begin
      cap_en   = 1'b1;
      cap_k    = 3'(GRP_WORDS) + {1'b0, off_ang[3:2]};
      cap_lane = off_ang[1:0];
    end
  end

  // Next frame state and result
  always_comb begin
    count_nxt     = count_r;
    xor_nxt       = xor_r;
    mark_bad_nxt  = mark_bad_r;
    sum_bad_nxt   = sum_bad_r;
    staged_nxt    = staged_r;
    good_nxt      = good_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    take_byte     = s1_adv && is_byte && (p < BUF_MAX);

    if (take_byte) begin
      count_nxt = p + 8'd1;
      if (miss1 || miss2 || miss3 || miss4 || miss_tail) begin
        mark_bad_nxt = 1'b1;
      end
      if (p < FL_SUM) begin
        xor_nxt = xor_r ^ b;
      end else if (p == FL_SUM) begin
        sum_bad_nxt = b != xor_r;
      end
      for (int w = 0; w < NWORDS; w++) begin
        for (int l = 0; l < 4; l++) begin
          if (cap_en && cap_k == 3'(w) && cap_lane == 2'(l)) begin
            staged_nxt[w][l*8 +: 8] = b;
          end
        end
      end
    end

    // Close the frame on an idle event
    if (s1_adv && is_idle) begin
      out_valid_nxt = 1'b1;
      if (count_r != FL) begin
        status_nxt = ST_BAD_LEN;
      end else if (mark_bad_r) begin
        status_nxt = ST_BAD_MARK;
      end else if (sum_bad_r) begin
        status_nxt = ST_BAD_SUM;
      end else begin
        status_nxt = ST_OK;
        good_nxt   = staged_r;
      end
      count_nxt    = '0;
      xor_nxt      = '0;
      mark_bad_nxt = 1'b0;
      sum_bad_nxt  = 1'b0;
    end
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      xor_r       <= '0;
      mark_bad_r  <= 1'b0;
      sum_bad_r   <= 1'b0;
      status_r    <= ST_OK;
      for (int w = 0; w < NWORDS; w++) begin
        staged_r[w] <= '0;
        good_r[w]   <= '0;
      end
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      xor_r       <= xor_nxt;
      mark_bad_r  <= mark_bad_nxt;
      sum_bad_r   <= sum_bad_nxt;
      status_r    <= status_nxt;
      staged_r    <= staged_nxt;
      good_r      <= good_nxt;
    end
  end

  // Hold the input payload until it advances
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  // Drive the result channel
  assign out_valid             = out_valid_r;
  assign out_data.frame_status = status_r;
  assign out_data.accel_x_bits = good_r[0];
  assign out_data.accel_y_bits = good_r[1];
  assign out_data.accel_z_bits = good_r[2];
  assign out_data.roll_bits    = good_r[3];
  assign out_data.pitch_bits   = good_r[4];
  assign out_data.yaw_bits     = good_r[5];

endmodule

/* sv/imu_fd_checker.sv */
// ----------------------------------------------------------------------------
// imu_fd_assertions
// Port-level checks of the IMU deframer, bound to the top level.
// ----------------------------------------------------------------------------
module imu_fd_assertions (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input imu_fd_pkg::in_item_t  in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input imu_fd_pkg::out_item_t out_data
);
  import imu_fd_pkg::*;

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result still valid after reset");

  // With no result held, input is never stalled
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Good accel x and yaw words change only with a newly shown ok result
  a_words_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (out_data.accel_x_bits != $past(out_data.accel_x_bits) ||
      out_data.yaw_bits != $past(out_data.yaw_bits)))
    |-> (out_valid && out_data.frame_status == ST_OK))
    else $error("good words changed without an ok frame");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // Waiting input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=> (in_valid && $stable(in_data)))
    else $error("waiting input item changed");

endmodule

bind imu_frame_deframer imu_fd_assertions u_imu_fd_assertions (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* test/imu_fd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fd_checker
// Watches both item channels of the IMU deframer and predicts every status
// item from the accepted input items: byte count, running XOR, marker and
// checksum flags, staged and last good words. Each accepted status item is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module imu_fd_checker
  import imu_fd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);

  localparam int FRAME_LEN = FRAME_LEN_DEF;
  localparam int BUF_SIZE  = BUF_SIZE_DEF;
  localparam int HEAD2_POS = HEAD2_POS_DEF;
  localparam int HEAD3_POS = HEAD3_POS_DEF;
  localparam int HEAD4_POS = HEAD4_POS_DEF;
  localparam int ACC_AT    = ACC_BASE;
  localparam int ANG_AT    = ANG_BASE;
  localparam int SPAN      = GRP_SPAN;
  localparam int MAX_NOTES = 10;

  // Marker sequences, first byte in the low lane
  localparam logic [47:0] LEAD_SEQ = 48'h47_81_06_FF_78_41;
  localparam logic [47:0] SYNC_SEQ = 48'h0C_8C_00;
  localparam logic [47:0] ACC_SEQ  = 48'h0C_8C_02;
  localparam logic [47:0] ANG_SEQ  = 48'h10_B0_01;

  logic [7:0]  seen_bytes;
  logic [7:0]  xor_acc;
  logic        marker_err;
  logic        sum_err;
  logic [31:0] staged [NWORDS];
  logic [31:0] last_good [NWORDS];
  out_item_t   status_q [$];
  int          mism = 0;

  function automatic logic window_miss(input int p, input int base, input int n,
                                       input logic [47:0] seq, input logic [7:0] b);
    return (p >= base) && (p < base + n) && (seq[8*(p-base) +: 8] != b);
  endfunction

  function automatic void clear_frame();
    seen_bytes = '0;
    xor_acc    = '0;
    marker_err = 1'b0;
    sum_err    = 1'b0;
  endfunction

  // Fold one received byte into the frame state; drop it once the buffer is full
  function automatic void absorb_byte(input logic [7:0] b);
    int p;
    int k;
    int lane;
    p = seen_bytes;
    k = -1;
    lane = 0;
    if (p < BUF_SIZE) begin
      seen_bytes = seen_bytes + 8'd1;
      if (window_miss(p, 0, HEAD1_LEN, LEAD_SEQ, b) ||
          window_miss(p, HEAD2_POS, HEADN_LEN, SYNC_SEQ, b) ||
          window_miss(p, HEAD3_POS, HEADN_LEN, ACC_SEQ, b) ||
          window_miss(p, HEAD4_POS, HEADN_LEN, ANG_SEQ, b) ||
          (p == FRAME_LEN - 1 && b != TAIL_BYTE))
        marker_err = 1'b1;
      if (p < FRAME_LEN - 2)
        xor_acc = xor_acc ^ b;
      else if (p == FRAME_LEN - 2)
        sum_err = (b != xor_acc);
      // Capture little-endian word lanes
      if (p >= ACC_AT && p < ACC_AT + SPAN) begin
        k = (p - ACC_AT) / 4;
        lane = (p - ACC_AT) % 4;
      end else if (p >= ANG_AT && p < ANG_AT + SPAN) begin
        k = GRP_WORDS + (p - ANG_AT) / 4;
        lane = (p - ANG_AT) % 4;
      end
      if (k >= 0)
        staged[k][8*lane +: 8] = b;
    end
  endfunction

  // Judge the frame on an idle event and build its status item
  function automatic out_item_t close_frame();
    out_item_t r;
    if (seen_bytes != FRAME_LEN)
      r.frame_status = ST_BAD_LEN;
    else if (marker_err)
      r.frame_status = ST_BAD_MARK;
    else if (sum_err)
      r.frame_status = ST_BAD_SUM;
    else begin
      r.frame_status = ST_OK;
      for (int i = 0; i < NWORDS; i++)
        last_good[i] = staged[i];
    end
    clear_frame();
    r.accel_x_bits = last_good[0];
    r.accel_y_bits = last_good[1];
    r.accel_z_bits = last_good[2];
    r.roll_bits    = last_good[3];
    r.pitch_bits   = last_good[4];
    r.yaw_bits     = last_good[5];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got, input bit note,
                                      inout bit bad);
    if (want !== got) begin
      bad = 1'b1;
      if (note)
        $display("ERROR: %s expected %h got %h", name, want, got);
    end
  endfunction

  // Compare outgoing items first, then advance the prediction with the input item
  always @(posedge clk) begin : watch
    out_item_t due_item;
    bit        bad;
    bit        note;
    if (!rst_n) begin
      clear_frame();
      for (int i = 0; i < NWORDS; i++) begin
        staged[i]    = '0;
        last_good[i] = '0;
      end
      status_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (out_valid && out_ready) begin
        note = (mism < MAX_NOTES);
        if (status_q.size() == 0) begin
          if (note)
            $display("ERROR: status item %h with none expected", out_data);
          mism++;
        end else begin
          due_item = status_q.pop_front();
          bad = 1'b0;
          check_field("frame_status", due_item.frame_status, out_data.frame_status,
                      note, bad);
          check_field("accel_x_bits", due_item.accel_x_bits, out_data.accel_x_bits,
                      note, bad);
          check_field("accel_y_bits", due_item.accel_y_bits, out_data.accel_y_bits,
                      note, bad);
          check_field("accel_z_bits", due_item.accel_z_bits, out_data.accel_z_bits,
                      note, bad);
          check_field("roll_bits", due_item.roll_bits, out_data.roll_bits, note, bad);
          check_field("pitch_bits", due_item.pitch_bits, out_data.pitch_bits, note, bad);
          check_field("yaw_bits", due_item.yaw_bits, out_data.yaw_bits, note, bad);
          if (bad)
            mism++;
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.opcode == OP_IDLE)
          status_q.push_back(close_frame());
        else
          absorb_byte(in_data.rx_byte);
      end
      fail_count <= mism;
      pending    <= status_q.size();
    end
  end

endmodule

/* test/imu_frame_deframer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_deframer_tb
// Drives byte and idle items into the IMU deframer: directed frames for
// every status and the buffer limits, then random frames, some well
// formed with random payload, plus corrupted, short, long and noise frames.
// Both sides stall at random in two of three phases; the checker scores.
// ----------------------------------------------------------------------------
module imu_frame_deframer_tb;
  import imu_fd_pkg::*;

  localparam int FRAME_LEN   = FRAME_LEN_DEF;
  localparam int BUF_SIZE    = BUF_SIZE_DEF;
  localparam int RAND_ITEMS  = 760;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 8;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int         fail_count;
  int         pending;
  int         quiet         = 0;
  int         send_idle_pct = 38;
  int         recv_idle_pct = 63;
  int         items_sent    = 0;
  logic [7:0] frame_q [$];

  imu_frame_deframer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  imu_fd_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet <= 0;
    else if (quiet >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  // Present one item, with a random gap before it, and hold until accepted
  task automatic send_item(input logic op, input logic [7:0] b);
    in_item_t v;
    v.opcode  = op;
    v.rx_byte = b;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i])
      send_item(OP_BYTE, frame_q[i]);
    send_item(OP_IDLE, 8'($urandom));
  endtask

  // Hold the sender until every predicted status item has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
  endtask

  // Well-formed frame; fill < 0 gives a random payload
  function automatic void make_frame(input int fill);
    logic [7:0] x;
    frame_q.delete();
    for (int i = 0; i < FRAME_LEN; i++)
      frame_q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    for (int i = 0; i < HEAD1_LEN; i++)
      frame_q[i] = head1_pat(3'(i));
    for (int i = 0; i < HEADN_LEN; i++) begin
      frame_q[HEAD2_POS_DEF + i] = head2_pat(2'(i));
      frame_q[HEAD3_POS_DEF + i] = head3_pat(2'(i));
      frame_q[HEAD4_POS_DEF + i] = head4_pat(2'(i));
    end
    x = '0;
    for (int i = 0; i < FRAME_LEN - 2; i++)
      x = x ^ frame_q[i];
    frame_q[FRAME_LEN - 2] = x;
    frame_q[FRAME_LEN - 1] = TAIL_BYTE;
  endfunction

  // Flip bits of one random marker byte, header through tail
  function automatic void spoil_marker();
    int sel;
    int pos;
    sel = $urandom_range(0, 15);
    if (sel < 6)
      pos = sel;
    else if (sel < 9)
      pos = HEAD2_POS_DEF + sel - 6;
    else if (sel < 12)
      pos = HEAD3_POS_DEF + sel - 9;
    else if (sel < 15)
      pos = HEAD4_POS_DEF + sel - 12;
    else
      pos = FRAME_LEN - 1;
    frame_q[pos] = frame_q[pos] ^ 8'($urandom_range(1, 255));
  endfunction

  function automatic void resize_frame(input int n);
    while (frame_q.size() > n)
      void'(frame_q.pop_back());
    while (frame_q.size() < n)
      frame_q.push_back(8'($urandom));
  endfunction

  initial begin
    int base;
    int phase;
    int want;
    int kind;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty frames, good frames at payload extremes, each failure
    send_item(OP_IDLE, 8'hFF);
    send_item(OP_IDLE, 8'h00);
    make_frame(0);
    send_frame();
    make_frame(255);
    send_frame();
    make_frame(-1);
    send_frame();
    make_frame(-1);
    frame_q[0] = frame_q[0] ^ 8'h80;
    send_frame();
    make_frame(-1);
    frame_q[FRAME_LEN - 1] = 8'h00;
    send_frame();
    make_frame(-1);
    spoil_marker();
    send_frame();
    make_frame(-1);
    frame_q[FRAME_LEN - 2] = frame_q[FRAME_LEN - 2] ^ 8'h01;
    send_frame();
    make_frame(-1);
    resize_frame(FRAME_LEN - 1);
    send_frame();
    make_frame(-1);
    resize_frame(FRAME_LEN + 1);
    send_frame();
    // Fill the buffer exactly, then overrun it
    make_frame(-1);
    resize_frame(BUF_SIZE);
    send_frame();
    make_frame(-1);
    resize_frame(BUF_SIZE + 40);
    send_frame();
    make_frame(-1);
    send_frame();
    wait_drained();

    // Random frames; switch stall profile in three phases
    base  = items_sent;
    phase = 0;
    while (items_sent - base < RAND_ITEMS) begin
      want = (items_sent - base) * 3 / RAND_ITEMS;
      if (want > 2)
        want = 2;
      if (want != phase) begin
        wait_drained();
        phase = want;
        if (phase == 1) begin
          send_idle_pct = 63;
          recv_idle_pct = 38;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      end
      kind = $urandom_range(0, 99);
      make_frame(-1);
      if (kind < 40) begin
      end else if (kind < 50)
        spoil_marker();
      else if (kind < 60)
        frame_q[FRAME_LEN - 2] = frame_q[FRAME_LEN - 2] ^ 8'($urandom_range(1, 255));
      else if (kind < 72)
        resize_frame($urandom_range(0, FRAME_LEN - 1));
      else if (kind < 80)
        resize_frame(FRAME_LEN + $urandom_range(1, 100));
      else begin
        frame_q.delete();
        resize_frame($urandom_range(0, 8));
      end
      send_frame();
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
sv/imu_fd_pkg.sv
sv/imu_frame_deframer.sv
sv/imu_fd_checker.sv
test/imu_fd_checker.sv
test/imu_frame_deframer_tb.sv
